@@ rtl/swhsr_pkg.sv @@
package swhsr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [15:0] START_LOW_RST   = 16'd2000;
  localparam logic [7:0]  RELEASE_HIGH_RST = 8'd30;
  localparam logic [9:0]  TIMEOUT_RST     = 10'd100;
  localparam logic [7:0]  THRESHOLD_RST   = 8'd40;

  localparam logic [15:0] TEMP_SIGN = 16'h8000;
  localparam logic [15:0] TEMP_MAG  = 16'h7FFF;

  typedef enum logic [1:0] {
    REG_START_LOW    = 2'd0,
    REG_RELEASE_HIGH = 2'd1,
    REG_TIMEOUT      = 2'd2,
    REG_THRESHOLD    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH  = 3'd2,
    PH_ACK   = 3'd3,
    PH_RLOW  = 3'd4,
    PH_RHIGH = 3'd5,
    PH_BLOW  = 3'd6,
    PH_BHIGH = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    LM_RELEASED = 2'd0,
    LM_LOW      = 2'd1,
    LM_HIGH     = 2'd2
  } line_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  line_mode;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } res_t;

endpackage

@@ rtl/single_wire_humidity_sensor_reader_top.sv @@
// result: a result beat is registered for every accepted tick
// throughput: one tick per cycle while in_stall is low; the sequencer state and the output
//   buffer both update in the cycle a tick is taken, and a two-deep output buffer absorbs a stall
// reset: rst is synchronous; it returns the sequencer to idle, empties the output
//   buffer and loads the timing registers with their default values
module single_wire_humidity_sensor_reader_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic                             pin_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       line_mode,
  output logic                             busy_res,
  output logic                             done_res,
  output logic [1:0]                       status,
  output logic [15:0]                      humidity,
  output logic signed [15:0]               temperature,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swhsr_pkg::ADDR_W-1:0]     paddr,
  input  logic [swhsr_pkg::DATA_W-1:0]     pwdata,
  output logic [swhsr_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);

  // configuration registers
  logic [15:0] start_low_us;
  logic [7:0]  release_high_us;
  logic [9:0]  timeout_us;
  logic [7:0]  bit_threshold_us;

  // sequencer state
  swhsr_pkg::phase_t phase, phase_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [5:0]        bit_index, bit_index_next;
  logic [swhsr_pkg::FRAME_BITS-1:0] frame_bits, frame_bits_next;

  // output buffer
  swhsr_pkg::res_t out_res, skid_res, res;
  logic            skid_valid;

  logic            in_fire, out_fire, cfg_wr;
  logic            finish;
  swhsr_pkg::status_t fin_status;
  logic [16:0]     tick_inc;
  logic            wait_level;
  logic            bit_val;
  logic [7:0]      b0, b1, b2, b3, b4, sum;
  logic [15:0]     raw_t;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_us     <= swhsr_pkg::START_LOW_RST;
      release_high_us  <= swhsr_pkg::RELEASE_HIGH_RST;
      timeout_us       <= swhsr_pkg::TIMEOUT_RST;
      bit_threshold_us <= swhsr_pkg::THRESHOLD_RST;
    end else if (cfg_wr) begin
      case (swhsr_pkg::reg_idx_t'(paddr[3:2]))
        swhsr_pkg::REG_START_LOW:    start_low_us     <= pwdata[15:0];
        swhsr_pkg::REG_RELEASE_HIGH: release_high_us  <= pwdata[7:0];
        swhsr_pkg::REG_TIMEOUT:      timeout_us       <= pwdata[9:0];
        swhsr_pkg::REG_THRESHOLD:    bit_threshold_us <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (swhsr_pkg::reg_idx_t'(paddr[3:2]))
      swhsr_pkg::REG_START_LOW:    prdata = {16'd0, start_low_us};
      swhsr_pkg::REG_RELEASE_HIGH: prdata = {24'd0, release_high_us};
      swhsr_pkg::REG_TIMEOUT:      prdata = {22'd0, timeout_us};
      swhsr_pkg::REG_THRESHOLD:    prdata = {24'd0, bit_threshold_us};
      default:                     prdata = '0;
    endcase
  end

  // line level that keeps the current wait phase going
  assign wait_level = !(phase == swhsr_pkg::PH_RLOW || phase == swhsr_pkg::PH_BLOW);
  assign tick_inc   = {1'b0, tick_count} + 17'd1;
  assign bit_val    = tick_count > {8'd0, bit_threshold_us};

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    frame_bits_next = frame_bits;
    finish          = 1'b0;
    fin_status      = swhsr_pkg::ST_OK;
    case (phase)
      swhsr_pkg::PH_IDLE: begin
        if (cmd) begin
          phase_next      = swhsr_pkg::PH_START;
          tick_count_next = '0;
          bit_index_next  = '0;
          frame_bits_next = '0;
        end
      end
      swhsr_pkg::PH_START: begin
        tick_count_next = tick_inc[15:0];
        if (tick_inc >= {1'b0, start_low_us}) begin
          phase_next      = (release_high_us == 8'd0) ? swhsr_pkg::PH_ACK
                                                      : swhsr_pkg::PH_HIGH;
          tick_count_next = '0;
        end
      end
      swhsr_pkg::PH_HIGH: begin
        tick_count_next = tick_inc[15:0];
        if (tick_inc >= {9'd0, release_high_us}) begin
          phase_next      = swhsr_pkg::PH_ACK;
          tick_count_next = '0;
        end
      end
      default: begin
        if (pin_level == wait_level) begin
          tick_count_next = tick_inc[15:0];
          if (tick_inc > {7'd0, timeout_us}) begin
            finish     = 1'b1;
            fin_status = swhsr_pkg::ST_TIMEOUT;
          end
        end else begin
          case (phase)
            swhsr_pkg::PH_ACK:   phase_next = swhsr_pkg::PH_RLOW;
            swhsr_pkg::PH_RLOW:  phase_next = swhsr_pkg::PH_RHIGH;
            swhsr_pkg::PH_RHIGH: phase_next = swhsr_pkg::PH_BLOW;
            swhsr_pkg::PH_BLOW:  phase_next = swhsr_pkg::PH_BHIGH;
            swhsr_pkg::PH_BHIGH: begin
              frame_bits_next = {frame_bits[swhsr_pkg::FRAME_BITS-2:0], bit_val};
              bit_index_next  = bit_index + 6'd1;
              if (bit_index_next >= 6'(swhsr_pkg::FRAME_BITS)) begin
                finish = 1'b1;
              end
              phase_next = swhsr_pkg::PH_BLOW;
            end
            default: phase_next = phase;
          endcase
          tick_count_next = 16'd1;
          // a zero timeout fails a fresh wait on its first tick
          if (!finish && timeout_us == 10'd0) begin
            finish     = 1'b1;
            fin_status = swhsr_pkg::ST_TIMEOUT;
          end
        end
      end
    endcase
    if (finish) begin
      phase_next      = swhsr_pkg::PH_IDLE;
      tick_count_next = '0;
    end
  end

  // frame decode, bytes msb first
  assign b0    = frame_bits_next[39:32];
  assign b1    = frame_bits_next[31:24];
  assign b2    = frame_bits_next[23:16];
  assign b3    = frame_bits_next[15:8];
  assign b4    = frame_bits_next[7:0];
  assign sum   = b0 + b1 + b2 + b3;
  assign raw_t = {b2, b3};

  always_comb begin
    res = '0;
    if (finish) begin
      res.done_res = 1'b1;
      res.status   = fin_status;
      if (fin_status == swhsr_pkg::ST_OK) begin
        if (sum != b4) begin
          res.status = swhsr_pkg::ST_CHECKSUM;
        end else begin
          res.humidity = {b0, b1};
          // sign-magnitude to two's complement; negative zero comes out as zero
          if ((raw_t & swhsr_pkg::TEMP_SIGN) != 16'd0) begin
            res.temperature = 16'd0 - (raw_t & swhsr_pkg::TEMP_MAG);
          end else begin
            res.temperature = raw_t;
          end
        end
      end
    end else begin
      res.busy_res = (phase_next != swhsr_pkg::PH_IDLE);
      case (phase_next)
        swhsr_pkg::PH_START: res.line_mode = swhsr_pkg::LM_LOW;
        swhsr_pkg::PH_HIGH:  res.line_mode = swhsr_pkg::LM_HIGH;
        default:             res.line_mode = swhsr_pkg::LM_RELEASED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= swhsr_pkg::PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      frame_bits <= '0;
    end else if (in_fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      frame_bits <= frame_bits_next;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign line_mode   = out_res.line_mode;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign status      = out_res.status;
  assign humidity    = out_res.humidity;
  assign temperature = $signed(out_res.temperature);

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == swhsr_pkg::PH_IDLE |-> tick_count == 16'd0)
    else $error("tick counter not cleared in idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 6'(swhsr_pkg::FRAME_BITS))
    else $error("bit index ran past the frame");

  a_done_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |->
      !out_res.busy_res && out_res.line_mode == swhsr_pkg::LM_RELEASED)
    else $error("finished beat still busy or driving the line");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |->
      out_res.status == swhsr_pkg::ST_OK && out_res.humidity == 16'd0)
    else $error("status or data set on a beat without done");

endmodule

@@ test/humidity_reader_checker.sv @@
`timescale 1ns / 1ps
module humidity_reader_checker
  import swhsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               cmd,
  input  logic               pin_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         line_mode,
  input  logic               busy_res,
  input  logic               done_res,
  input  logic [1:0]         status,
  input  logic [15:0]        humidity,
  input  logic signed [15:0] temperature,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  output int                 fail_count,
  output int                 pending,
  output logic               reader_busy,
  output int                 reads_ok,
  output int                 reads_timed_out,
  output int                 reads_bad_sum
);

  typedef struct packed {
    phase_t      phase;
    logic [15:0] ticks;
    logic [5:0]  bits_seen;
    logic [39:0] frame;
  } reader_t;

  typedef struct packed {
    logic [15:0] start_low;
    logic [7:0]  release_high;
    logic [9:0]  timeout;
    logic [7:0]  threshold;
  } timing_t;

  reader_t     rd;
  timing_t     tm;
  res_t        predicted_reports[$];
  int unsigned ticks_in;
  int unsigned reports_out;

  assign pending     = int'(ticks_in - reports_out);
  assign reader_busy = (rd.phase != PH_IDLE);

  // ends a read: back to idle, decode the frame when it completed
  function automatic res_t close_read(inout reader_t s, input status_t st);
    logic [15:0] hum;
    logic [15:0] tmp;
    logic [7:0]  sum;
    res_t        r;
    r          = '0;
    r.done_res = 1'b1;
    r.status   = st;
    s.phase    = PH_IDLE;
    s.ticks    = '0;
    hum        = s.frame[39:24];
    tmp        = s.frame[23:8];
    sum        = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
    if (st == ST_OK) begin
      if (sum != s.frame[7:0]) begin
        r.status = ST_CHECKSUM;
      end else begin
        r.humidity    = hum;
        // sign-magnitude to two's complement, negative zero comes out as zero
        r.temperature = ((tmp & TEMP_SIGN) != 0) ? 16'h0000 - (tmp & TEMP_MAG) : tmp;
      end
    end
    return r;
  endfunction

  function automatic res_t step_reader(inout reader_t s, input timing_t t,
                                       input logic c, input logic p);
    res_t r;
    logic keep_level;
    r = '0;
    case (s.phase)
      PH_IDLE: begin
        if (c) begin
          s.phase     = PH_START;
          s.ticks     = '0;
          s.bits_seen = '0;
          s.frame     = '0;
        end
      end
      PH_START: begin
        s.ticks = s.ticks + 16'd1;
        if (s.ticks >= t.start_low) begin
          s.phase = (t.release_high == 0) ? PH_ACK : PH_HIGH;
          s.ticks = '0;
        end
      end
      PH_HIGH: begin
        s.ticks = s.ticks + 16'd1;
        if (s.ticks >= 16'(t.release_high)) begin
          s.phase = PH_ACK;
          s.ticks = '0;
        end
      end
      default: begin
        keep_level = !(s.phase == PH_RLOW || s.phase == PH_BLOW);
        if (p == keep_level) begin
          s.ticks = s.ticks + 16'd1;
          if (s.ticks > 16'(t.timeout)) return close_read(s, ST_TIMEOUT);
        end else begin
          if (s.phase == PH_BHIGH) begin
            s.frame     = {s.frame[38:0], (s.ticks > 16'(t.threshold))};
            s.bits_seen = s.bits_seen + 6'd1;
            if (s.bits_seen >= FRAME_BITS) return close_read(s, ST_OK);
            s.phase = PH_BLOW;
          end else begin
            s.phase = phase_t'(s.phase + 3'd1);
          end
          // the edge sample is the first tick of the new wait
          s.ticks = 16'd1;
          if (s.ticks > 16'(t.timeout)) return close_read(s, ST_TIMEOUT);
        end
      end
    endcase
    if (s.phase == PH_START) r.line_mode = LM_LOW;
    else if (s.phase == PH_HIGH) r.line_mode = LM_HIGH;
    else r.line_mode = LM_RELEASED;
    r.busy_res = (s.phase != PH_IDLE);
    return r;
  endfunction

  function automatic int field_diff(input string nm, input logic signed [31:0] want,
                                    input logic signed [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", nm, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    reader_t     nxt;
    res_t        predicted;
    res_t        oldest;
    int          n_bad;
    logic [31:0] reg_want;
    n_bad = 0;
    if (rst) begin
      rd <= '{phase: PH_IDLE, ticks: '0, bits_seen: '0, frame: '0};
      tm <= '{start_low: START_LOW_RST, release_high: RELEASE_HIGH_RST,
              timeout: TIMEOUT_RST, threshold: THRESHOLD_RST};
      predicted_reports.delete();
      ticks_in        <= 0;
      reports_out     <= 0;
      fail_count      <= 0;
      reads_ok        <= 0;
      reads_timed_out <= 0;
      reads_bad_sum   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_START_LOW:    tm.start_low    <= pwdata[15:0];
          REG_RELEASE_HIGH: tm.release_high <= pwdata[7:0];
          REG_TIMEOUT:      tm.timeout      <= pwdata[9:0];
          REG_THRESHOLD:    tm.threshold    <= pwdata[7:0];
          default: ;
        endcase
      end
      // register read-back against the expected timing values
      if (psel && penable && !pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_START_LOW:    reg_want = {16'd0, tm.start_low};
          REG_RELEASE_HIGH: reg_want = {24'd0, tm.release_high};
          REG_TIMEOUT:      reg_want = {22'd0, tm.timeout};
          REG_THRESHOLD:    reg_want = {24'd0, tm.threshold};
          default:          reg_want = '0;
        endcase
        n_bad = n_bad + field_diff("prdata", reg_want, prdata);
      end
      if (in_valid && !in_stall) begin
        nxt       = rd;
        predicted = step_reader(nxt, tm, cmd, pin_level);
        rd       <= nxt;
        predicted_reports.push_back(predicted);
        ticks_in <= ticks_in + 1;
        if (predicted.done_res) begin
          case (status_t'(predicted.status))
            ST_OK:       reads_ok        <= reads_ok + 1;
            ST_TIMEOUT:  reads_timed_out <= reads_timed_out + 1;
            ST_CHECKSUM: reads_bad_sum   <= reads_bad_sum + 1;
            default: ;
          endcase
        end
      end
      if (out_valid && !out_stall) begin
        reports_out <= reports_out + 1;
        if (predicted_reports.size() == 0) begin
          $error("result beat with no tick waiting for it");
          n_bad = n_bad + 1;
        end else begin
          oldest = predicted_reports.pop_front();
          n_bad  = n_bad
                 + field_diff("line_mode", oldest.line_mode, line_mode)
                 + field_diff("busy_res", oldest.busy_res, busy_res)
                 + field_diff("done_res", oldest.done_res, done_res)
                 + field_diff("status", oldest.status, status)
                 + field_diff("humidity", oldest.humidity, humidity)
                 + field_diff("temperature", $signed(oldest.temperature), temperature);
        end
      end
      fail_count <= fail_count + n_bad;
    end
  end

endmodule

@@ test/single_wire_humidity_sensor_reader_top_test.sv @@
`timescale 1ns / 1ps
module single_wire_humidity_sensor_reader_top_test;
  import swhsr_pkg::*;

  localparam int QUIET_LIMIT     = 1000;
  localparam int RANDOM_PHASES   = 3;
  localparam int TICKS_PER_PHASE = 80;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic               pin_level;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         line_mode;
  logic               busy_res;
  logic               done_res;
  logic [1:0]         status;
  logic [15:0]        humidity;
  logic signed [15:0] temperature;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int   fail_count;
  int   pending;
  logic reader_busy;
  int   reads_ok;
  int   reads_timed_out;
  int   reads_bad_sum;

  // timing the sensor side must honor, kept in step with the register writes
  int unsigned cfg_start   = START_LOW_RST;
  int unsigned cfg_release = RELEASE_HIGH_RST;
  int unsigned cfg_timeout = TIMEOUT_RST;
  int unsigned cfg_thr     = THRESHOLD_RST;

  bit          idling      = 1'b1;
  int unsigned ticks_sent  = 0;
  int unsigned settings    = 0;
  int          stall_left  = 0;
  int          quiet       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  single_wire_humidity_sensor_reader_top DUT (.*);

  humidity_reader_checker reader_check (.*);

  always @(posedge clk) begin
    if (rst || !idling) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic c, input logic p);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    pin_level <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic hold_line(input logic level, input int unsigned n);
    repeat (n) send_tick(1'b0, level);
  endtask

  // run length of one wait; now and then one tick past the timeout
  function automatic int unsigned run_len(input int unsigned lo, input int unsigned hi,
                                          input int unsigned fault_odds);
    if (fault_odds != 0 && $urandom_range(1, fault_odds) == 1) return cfg_timeout + 1;
    if (hi > cfg_timeout) hi = cfg_timeout;
    if (hi < lo) hi = lo;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [39:0] pack_frame(input logic [15:0] hum, input logic [15:0] tmp,
                                             input logic corrupt);
    logic [7:0] sum;
    sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    return {hum, tmp, sum};
  endfunction

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_reg(input reg_idx_t idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    read_reg(REG_START_LOW);
    read_reg(REG_RELEASE_HIGH);
    read_reg(REG_TIMEOUT);
    read_reg(REG_THRESHOLD);
  endtask

  task automatic set_timing(input int unsigned start_low, input int unsigned release_high,
                            input int unsigned timeout, input int unsigned threshold);
    in_valid <= 1'b0;
    @(posedge clk);
    // let a read left open by noise run out first
    while (reader_busy) send_tick(1'b0, 1'b1);
    in_valid <= 1'b0;
    write_reg(REG_START_LOW, start_low);
    write_reg(REG_RELEASE_HIGH, release_high);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_THRESHOLD, threshold);
    check_regs();
    cfg_start   = start_low;
    cfg_release = release_high;
    cfg_timeout = timeout;
    cfg_thr     = threshold;
    settings++;
  endtask

  // one read as the sensor would answer it; the pin is don't-care while driven
  task automatic sensor_read(input logic [39:0] frame, input int unsigned ack_ticks,
                             input int unsigned fault_odds);
    int unsigned lead;
    lead = (cfg_start == 0 ? 1 : cfg_start) + cfg_release;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (lead) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    hold_line(1'b1, ack_ticks);
    hold_line(1'b0, run_len(1, cfg_timeout, fault_odds));
    hold_line(1'b1, run_len(1, cfg_timeout, fault_odds));
    for (int i = 39; i >= 0; i--) begin
      hold_line(1'b0, run_len(1, 3, fault_odds));
      hold_line(1'b1, frame[i] ? run_len(cfg_thr + 1, cfg_thr + 3, fault_odds)
                               : run_len(1, cfg_thr, fault_odds));
    end
    send_tick(1'b0, 1'b0);
  endtask

  initial begin
    int unsigned tmo;
    int unsigned thr;
    int unsigned stop;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cmd       <= 1'b0;
    pin_level <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // timing registers come out of reset with their defaults
    check_regs();

    // plain ticks while idle
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // shortest drive, no release phase; the sensor never answers and a long wait runs out
    set_timing(0, 0, 300, 255);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    hold_line(1'b1, 301);

    // long drive and release, zero timeout fails the first wait
    set_timing(260, 130, 0, 0);
    sensor_read(pack_frame(16'h0001, 16'h0001, 1'b0), 0, 0);

    // zero threshold turns every pulse into a one
    set_timing(1, 1, 20, 0);
    sensor_read(pack_frame(16'h0000, 16'h0000, 1'b0), 2, 0);

    set_timing(3, 2, 12, 4);
    sensor_read(pack_frame(16'hFFFF, TEMP_SIGN, 1'b0), 3, 0);
    sensor_read(pack_frame(16'h0190, TEMP_MAG, 1'b0), 3, 0);
    sensor_read(pack_frame(16'h02A5, 16'h80C8, 1'b1), 3, 0);
    sensor_read(pack_frame(16'h02A5, 16'h80C8, 1'b0), 0, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tmo = $urandom_range(8, 16);
      thr = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
      set_timing(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24),
                 $urandom_range(0, 8), tmo, thr);
      if (ph == RANDOM_PHASES - 1) idling <= 1'b0;
      stop = ticks_sent + TICKS_PER_PHASE;
      while (ticks_sent < stop) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 12))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          1: sensor_read(pack_frame(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1))),
                         $urandom_range(0, 4), 40);
          default: sensor_read(pack_frame(16'($urandom), 16'($urandom),
                                          $urandom_range(0, 7) == 0),
                               $urandom_range(0, 4), 0);
        endcase
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    $display("%0d sensor ticks over %0d timing settings", ticks_sent, settings);
    $display("reads ended: %0d ok, %0d timed out, %0d bad checksum",
             reads_ok, reads_timed_out, reads_bad_sum);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
